// ===== sv/wsd_pkg.sv =====
// Shared types, codes and the opcode decode for the WebSocket frame deframer.
// Used by wsd_parser, websocket_frame_deframer_top and wsd_checker; no dependencies.
package wsd_pkg;

  localparam logic IN_KIND_BYTE  = 1'b0;
  localparam logic IN_KIND_RESET = 1'b1;

  localparam logic [2:0] FK_TEXT   = 3'd0;
  localparam logic [2:0] FK_BINARY = 3'd1;
  localparam logic [2:0] FK_CLOSE  = 3'd2;
  localparam logic [2:0] FK_PING   = 3'd3;
  localparam logic [2:0] FK_PONG   = 3'd4;
  localparam logic [2:0] FK_OTHER  = 3'd5;

  localparam logic [2:0] OC_OK       = 3'd0;
  localparam logic [2:0] OC_CLOSE    = 3'd1;
  localparam logic [2:0] OC_UNMASKED = 3'd2;
  localparam logic [2:0] OC_BAD_OP   = 3'd3;
  localparam logic [2:0] OC_IGNORED  = 3'd4;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [2:0]  frame_kind;
    logic        header_done;
    logic [63:0] payload_length;
    logic        frame_end;
    logic [2:0]  outcome;
  } result_t;

  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] k;
    unique case (op)
      OP_TEXT:   k = FK_TEXT;
      OP_BINARY: k = FK_BINARY;
      OP_CLOSE:  k = FK_CLOSE;
      OP_PING:   k = FK_PING;
      OP_PONG:   k = FK_PONG;
      default:   k = FK_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/wsd_parser.sv =====
// Per-byte frame parser: holds the header, mask key and length state and
// forms one result per accepted item. Depends on wsd_pkg.
module wsd_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             kind_i,
  input  logic [7:0]       data_byte_i,
  output wsd_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_PAY,
    PH_CLOSED
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  hcount_q, hcount_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [63:0] length_q, length_d;
  logic [31:0] key_q, key_d;
  logic [63:0] left_q, left_d;
  logic [1:0]  kidx_q, kidx_d;

  logic [3:0]  hcount_dec;
  logic [7:0]  key_byte;
  logic [2:0]  cur_kind;
  logic [2:0]  end_outcome;
  phase_e      end_phase;

  assign hcount_dec = hcount_q - 4'd1;
  assign cur_kind   = wsd_pkg::kind_of(opcode_q);

  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Outcome and next phase when the current frame completes.
  always_comb begin
    case (cur_kind)
      wsd_pkg::FK_CLOSE: begin
        end_outcome = wsd_pkg::OC_CLOSE;
        end_phase   = PH_CLOSED;
      end
      wsd_pkg::FK_OTHER: begin
        end_outcome = wsd_pkg::OC_BAD_OP;
        end_phase   = PH_CLOSED;
      end
      default: begin
        end_outcome = wsd_pkg::OC_OK;
        end_phase   = PH_HDR0;
      end
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    hcount_d = hcount_q;
    opcode_d = opcode_q;
    mask_d   = mask_q;
    length_d = length_q;
    key_d    = key_q;
    left_d   = left_q;
    kidx_d   = kidx_q;
    res_o    = '0;

    if (kind_i == wsd_pkg::IN_KIND_RESET) begin
      phase_d  = PH_HDR0;
      hcount_d = '0;
      opcode_d = '0;
      mask_d   = 1'b0;
      length_d = '0;
      key_d    = '0;
      left_d   = '0;
      kidx_d   = '0;
    end else begin
      unique case (phase_q)
        PH_HDR0: begin
          opcode_d = data_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d   = data_byte_i[7];
          length_d = '0;
          if (data_byte_i[6:0] == wsd_pkg::LEN_EXT16) begin
            hcount_d = wsd_pkg::EXT16_BYTES;
            phase_d  = PH_EXT;
          end else if (data_byte_i[6:0] == wsd_pkg::LEN_EXT64) begin
            hcount_d = wsd_pkg::EXT64_BYTES;
            phase_d  = PH_EXT;
          end else begin
            length_d = {57'd0, data_byte_i[6:0]};
            if (!data_byte_i[7]) begin
              res_o.outcome = wsd_pkg::OC_UNMASKED;
              phase_d       = PH_CLOSED;
            end else begin
              hcount_d = wsd_pkg::KEY_BYTES;
              phase_d  = PH_KEY;
            end
          end
        end
        PH_EXT: begin
          length_d = {length_q[55:0], data_byte_i};
          hcount_d = hcount_dec;
          if (hcount_dec == 4'd0) begin
            if (!mask_q) begin
              res_o.outcome = wsd_pkg::OC_UNMASKED;
              phase_d       = PH_CLOSED;
            end else begin
              hcount_d = wsd_pkg::KEY_BYTES;
              phase_d  = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          key_d    = {key_q[23:0], data_byte_i};
          hcount_d = hcount_dec;
          if (hcount_dec == 4'd0) begin
            res_o.header_done    = 1'b1;
            res_o.payload_length = length_q;
            left_d               = length_q;
            kidx_d               = '0;
            if (length_q == 64'd0) begin
              res_o.frame_end = 1'b1;
              res_o.outcome   = end_outcome;
              phase_d         = end_phase;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          if (cur_kind != wsd_pkg::FK_OTHER) begin
            res_o.payload_byte  = data_byte_i ^ key_byte;
            res_o.payload_valid = 1'b1;
          end
          kidx_d = kidx_q + 2'd1;
          left_d = left_q - 64'd1;
          if (left_q == 64'd1) begin
            res_o.frame_end = 1'b1;
            res_o.outcome   = end_outcome;
            phase_d         = end_phase;
          end
        end
        default: begin
          phase_d = PH_CLOSED;
        end
      endcase

      if (phase_q == PH_CLOSED) begin
        res_o.outcome = wsd_pkg::OC_IGNORED;
      end else begin
        res_o.frame_kind = wsd_pkg::kind_of(opcode_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      hcount_q <= '0;
      opcode_q <= '0;
      mask_q   <= 1'b0;
      length_q <= '0;
      key_q    <= '0;
      left_q   <= '0;
      kidx_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      hcount_q <= hcount_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      length_q <= length_d;
      key_q    <= key_d;
      left_q   <= left_d;
      kidx_q   <= kidx_d;
    end
  end

endmodule

// ===== sv/websocket_frame_deframer_top.sv =====
// Top level of the WebSocket frame deframer: input handshake, parser and result register.
// Depends on wsd_pkg and wsd_parser.
//
//   channel  direction  handshake              payload
//   input    in         in_valid_i/in_stall_o  kind_i, data_byte_i
//   result   out        out_valid_o/out_stall_i payload_byte_o .. outcome_o
//
// Every accepted item yields exactly one result in the cycle after, and one item is taken
// per cycle while unstalled. The parser state and the result register load in the same cycle,
// so the rate is set by the result register alone: the input stalls only while a held result
// is itself stalled. Reset clears the parser state and the result valid flag.
module websocket_frame_deframer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic [2:0]  frame_kind_o,
  output logic        header_done_o,
  output logic [63:0] payload_length_o,
  output logic        frame_end_o,
  output logic [2:0]  outcome_o
);

  logic             accept;
  logic             out_valid_q;
  wsd_pkg::result_t res;
  wsd_pkg::result_t res_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign payload_byte_o   = res_q.payload_byte;
  assign payload_valid_o  = res_q.payload_valid;
  assign frame_kind_o     = res_q.frame_kind;
  assign header_done_o    = res_q.header_done;
  assign payload_length_o = res_q.payload_length;
  assign frame_end_o      = res_q.frame_end;
  assign outcome_o        = res_q.outcome;

endmodule

// ===== sv/wsd_checker.sv =====
// Port-level checks for the WebSocket frame deframer, bound to the top level.
// Depends on wsd_pkg and websocket_frame_deframer_top.
module wsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  payload_byte_o,
  input logic        payload_valid_o,
  input logic [2:0]  frame_kind_o,
  input logic        header_done_o,
  input logic [63:0] payload_length_o,
  input logic        frame_end_o,
  input logic [2:0]  outcome_o
);

  // A stalled result stays valid with the same payload byte, outcome, length and frame end.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(outcome_o) && $stable(payload_length_o) && $stable(frame_end_o))
    else $error("stalled result changed");

  // A payload byte never coincides with the header completing or with an unsupported frame kind.
  a_pay_not_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> !header_done_o && frame_kind_o != wsd_pkg::FK_OTHER)
    else $error("payload byte on header byte or unsupported frame");

  // A length is only reported with header completion.
  a_len_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !header_done_o |-> payload_length_o == 64'd0)
    else $error("length reported outside header completion");

  // Ignored bytes carry nothing else.
  a_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == wsd_pkg::OC_IGNORED |->
      !payload_valid_o && frame_kind_o == wsd_pkg::FK_TEXT && !frame_end_o && !header_done_o)
    else $error("ignored byte carries data");

  // An unmasked frame error never completes a frame or a header.
  a_unmasked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == wsd_pkg::OC_UNMASKED |-> !frame_end_o && !header_done_o)
    else $error("unmasked error with frame or header completion");

endmodule

bind websocket_frame_deframer_top wsd_checker u_wsd_checker (.*);
